// ===== hdl/hgg_pkg.sv =====
package hgg_pkg;

  // Grid geometry
  localparam int unsigned GRID_SIDE = 128;
  localparam int unsigned IDX_W     = $clog2(GRID_SIDE);
  localparam int unsigned IN_W      = 7;
  localparam int unsigned CNT_W     = 3;
  // Width that holds an input index and the side for the wrap reduction
  localparam int unsigned RED_W     = ((IN_W > IDX_W) ? IN_W : IDX_W) + 1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [GRID_SIDE-1:0] row_t;
  typedef logic [RED_W-1:0]     red_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_COUNT,
    ST_WRITE
  } state_e;

  // Which row of the neighborhood is on the memory read port
  typedef enum logic [1:0] {
    TAP_UP,
    TAP_MID,
    TAP_DN
  } tap_e;

  typedef struct packed {
    logic clr;
    logic acc;
    tap_e tap;
  } nbr_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             after;
    logic             newly;
  } nbr_res_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    row_t wdata;
    idx_t raddr;
  } mem_req_t;

  // Index plus one, wrapping at the grid side
  function automatic idx_t wrap_inc(idx_t v);
    return (v == idx_t'(GRID_SIDE - 1)) ? '0 : v + idx_t'(1);
  endfunction

  // Index minus one, wrapping at the grid side
  function automatic idx_t wrap_dec(idx_t v);
    return (v == '0) ? idx_t'(GRID_SIDE - 1) : v - idx_t'(1);
  endfunction

  // Reset contents of one grid row: seed hexagon around the center cell
  function automatic row_t seed_row(idx_t r);
    row_t w;
    idx_t c;
    w = '0;
    c = idx_t'(GRID_SIDE / 2);
    if (r == wrap_dec(c)) begin
      w[c]           = 1'b1;
      w[wrap_inc(c)] = 1'b1;
    end
    if (r == c) begin
      w[wrap_dec(c)] = 1'b1;
      w[c]           = 1'b1;
      w[wrap_inc(c)] = 1'b1;
    end
    if (r == wrap_inc(c)) begin
      w[wrap_dec(c)] = 1'b1;
      w[c]           = 1'b1;
    end
    return w;
  endfunction

endpackage

// ===== hdl/hgg_grid_mem.sv =====
module hgg_grid_mem (
  input  logic              clk_i,
  input  hgg_pkg::mem_req_t req_i,
  output hgg_pkg::row_t     rd_row_o
);

  // One row of the grid per word, one write and one read port
  hgg_pkg::row_t grid_q [hgg_pkg::GRID_SIDE];
  hgg_pkg::row_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      grid_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= grid_q[req_i.raddr];
  end

  assign rd_row_o = rd_q;

endmodule

// ===== hdl/hgg_nbr_unit.sv =====
module hgg_nbr_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hgg_pkg::nbr_ctrl_t     ctrl_i,
  input  hgg_pkg::idx_t          col_i,
  input  hgg_pkg::row_t          rd_row_i,
  input  logic [hgg_pkg::CNT_W-1:0] thr_i,
  output hgg_pkg::nbr_res_t      res_o,
  output hgg_pkg::row_t          wb_row_o
);

  logic [hgg_pkg::CNT_W-1:0] acc_q, acc_d;
  logic                      own_q, own_d;
  hgg_pkg::row_t             mid_q, mid_d;
  hgg_pkg::idx_t             col_m, col_p;
  logic                      b0, b1;
  logic [hgg_pkg::CNT_W-1:0] add;
  logic                      after;
  hgg_pkg::row_t             wb_row;

  // Pick the two neighbor bits that live in the row on the read port
  always_comb begin
    col_m = hgg_pkg::wrap_dec(col_i);
    col_p = hgg_pkg::wrap_inc(col_i);
    case (ctrl_i.tap)
      hgg_pkg::TAP_UP: begin
        b0 = rd_row_i[col_i];
        b1 = rd_row_i[col_p];
      end
      hgg_pkg::TAP_MID: begin
        b0 = rd_row_i[col_m];
        b1 = rd_row_i[col_p];
      end
      hgg_pkg::TAP_DN: begin
        b0 = rd_row_i[col_i];
        b1 = rd_row_i[col_m];
      end
      default: begin
        b0 = 1'b0;
        b1 = 1'b0;
      end
    endcase
    add = {{(hgg_pkg::CNT_W-1){1'b0}}, b0} + {{(hgg_pkg::CNT_W-1){1'b0}}, b1};
  end

  // Shared adder; the own row is kept for the write-back
  always_comb begin
    acc_d = acc_q;
    own_d = own_q;
    mid_d = mid_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc) begin
      acc_d = acc_q + add;
      if (ctrl_i.tap == hgg_pkg::TAP_MID) begin
        own_d = rd_row_i[col_i];
        mid_d = rd_row_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q <= own_d;
    mid_q <= mid_d;
  end

  // Growth decision and updated row
  always_comb begin
    after          = own_q | (acc_q >= thr_i);
    wb_row         = mid_q;
    wb_row[col_i]  = after;
    res_o.count    = acc_q;
    res_o.after    = after;
    res_o.newly    = after & ~own_q;
  end

  assign wb_row_o = wb_row;

endmodule

// ===== hdl/hgg_ctrl.sv =====
module hgg_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [hgg_pkg::IN_W-1:0]  row_i,
  input  logic [hgg_pkg::IN_W-1:0]  col_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hgg_pkg::CNT_W-1:0] neighbour_count_o,
  output logic                      occupied_after_o,
  output logic                      newly_set_o,
  input  hgg_pkg::nbr_res_t         res_i,
  input  hgg_pkg::row_t             wb_row_i,
  output hgg_pkg::nbr_ctrl_t        nbr_ctrl_o,
  output hgg_pkg::idx_t             col_o,
  output hgg_pkg::mem_req_t         mem_req_o
);

  hgg_pkg::state_e  state_q, state_d;
  hgg_pkg::red_t    row_q, row_d, col_q, col_d;
  hgg_pkg::idx_t    clr_cnt_q, clr_cnt_d;
  logic             out_valid_q, out_valid_d;
  hgg_pkg::nbr_res_t out_q;
  hgg_pkg::idx_t    row_idx;
  logic             out_free;
  logic             row_big, col_big;
  logic             load_out;

  assign row_idx  = row_q[hgg_pkg::IDX_W-1:0];
  assign col_o    = col_q[hgg_pkg::IDX_W-1:0];
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign row_big  = row_q >= hgg_pkg::red_t'(hgg_pkg::GRID_SIDE);
  assign col_big  = col_q >= hgg_pkg::red_t'(hgg_pkg::GRID_SIDE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hgg_pkg::ST_CLEAR: begin
        if (clr_cnt_q == hgg_pkg::idx_t'(hgg_pkg::GRID_SIDE - 1)) begin
          state_d = hgg_pkg::ST_IDLE;
        end
      end
      hgg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = hgg_pkg::ST_REDUCE;
        end
      end
      hgg_pkg::ST_REDUCE: begin
        if (!row_big && !col_big) begin
          state_d = hgg_pkg::ST_RD_UP;
        end
      end
      hgg_pkg::ST_RD_UP:  state_d = hgg_pkg::ST_RD_MID;
      hgg_pkg::ST_RD_MID: state_d = hgg_pkg::ST_RD_DN;
      hgg_pkg::ST_RD_DN:  state_d = hgg_pkg::ST_COUNT;
      hgg_pkg::ST_COUNT:  state_d = hgg_pkg::ST_WRITE;
      hgg_pkg::ST_WRITE: begin
        if (out_free) begin
          state_d = hgg_pkg::ST_IDLE;
        end
      end
      default: state_d = hgg_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o      = (state_q != hgg_pkg::ST_IDLE);
    nbr_ctrl_o.clr  = (state_q == hgg_pkg::ST_REDUCE);
    nbr_ctrl_o.acc  = 1'b0;
    nbr_ctrl_o.tap  = hgg_pkg::TAP_UP;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = row_idx;
    mem_req_o.wdata = wb_row_i;
    mem_req_o.raddr = row_idx;
    load_out        = 1'b0;
    case (state_q)
      hgg_pkg::ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_cnt_q;
        mem_req_o.wdata = hgg_pkg::seed_row(clr_cnt_q);
      end
      hgg_pkg::ST_RD_UP: begin
        mem_req_o.raddr = hgg_pkg::wrap_dec(row_idx);
      end
      hgg_pkg::ST_RD_MID: begin
        nbr_ctrl_o.acc  = 1'b1;
        nbr_ctrl_o.tap  = hgg_pkg::TAP_UP;
      end
      hgg_pkg::ST_RD_DN: begin
        mem_req_o.raddr = hgg_pkg::wrap_inc(row_idx);
        nbr_ctrl_o.acc  = 1'b1;
        nbr_ctrl_o.tap  = hgg_pkg::TAP_MID;
      end
      hgg_pkg::ST_COUNT: begin
        nbr_ctrl_o.acc  = 1'b1;
        nbr_ctrl_o.tap  = hgg_pkg::TAP_DN;
      end
      hgg_pkg::ST_WRITE: begin
        mem_req_o.we    = out_free;
        load_out        = out_free;
      end
      default: begin
      end
    endcase
  end

  // Clear counter, index capture, wrap reduction (one subtraction per cycle) and output valid
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    clr_cnt_d = clr_cnt_q;
    if (state_q == hgg_pkg::ST_CLEAR) begin
      clr_cnt_d = clr_cnt_q + hgg_pkg::idx_t'(1);
    end
    if (state_q == hgg_pkg::ST_IDLE && in_valid_i) begin
      row_d = hgg_pkg::red_t'(row_i);
      col_d = hgg_pkg::red_t'(col_i);
    end else if (state_q == hgg_pkg::ST_REDUCE) begin
      if (row_big) begin
        row_d = row_q - hgg_pkg::red_t'(hgg_pkg::GRID_SIDE);
      end else if (col_big) begin
        col_d = col_q - hgg_pkg::red_t'(hgg_pkg::GRID_SIDE);
      end
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hgg_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    if (load_out) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign neighbour_count_o = out_q.count;
  assign occupied_after_o  = out_q.after;
  assign newly_set_o       = out_q.newly;

endmodule

// ===== hdl/hex_grid_growth_step.sv =====
// Hexagonal-lattice growth step on a GRID_SIDE x GRID_SIDE torus (128 x 128).
// Each request names a cell by row and column (reduced modulo the side); the
// block counts occupied cells among its six hexagonal neighbors, sets the cell
// when the count reaches min_neighbours, and returns the count, the cell's new
// state and whether it was just set. The grid lives in a row-wide memory, one
// grid row per word. After reset a clearing pass writes the seed pattern, one
// row per cycle, over all GRID_SIDE rows (128); requests are stalled meanwhile,
// configuration writes are taken at any time. Each request runs from
// acceptance until its write-back before the next is accepted: three row reads
// through the single memory read port feed the shared neighbor counter, then
// the row is written back and the result lands in the output register. A wrap
// subtraction is made for an index at or above the side (none at side 128).
// A finished result may wait in the output register while the next request
// is accepted; the write-back waits only when that register is still full.
module hex_grid_growth_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hgg_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [hgg_pkg::IN_W-1:0]  row_i,
  input  logic [hgg_pkg::IN_W-1:0]  col_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hgg_pkg::CNT_W-1:0] neighbour_count_o,
  output logic                      occupied_after_o,
  output logic                      newly_set_o
);

  logic [hgg_pkg::CNT_W-1:0] min_nbr_q;
  hgg_pkg::nbr_ctrl_t        nbr_ctrl;
  hgg_pkg::nbr_res_t         nbr_res;
  hgg_pkg::mem_req_t         mem_req;
  hgg_pkg::row_t             rd_row;
  hgg_pkg::row_t             wb_row;
  hgg_pkg::idx_t             col_idx;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_nbr_q <= hgg_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      min_nbr_q <= cfg_wdata_i;
    end
  end

  hgg_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .row_i             (row_i),
    .col_i             (col_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .neighbour_count_o (neighbour_count_o),
    .occupied_after_o  (occupied_after_o),
    .newly_set_o       (newly_set_o),
    .res_i             (nbr_res),
    .wb_row_i          (wb_row),
    .nbr_ctrl_o        (nbr_ctrl),
    .col_o             (col_idx),
    .mem_req_o         (mem_req)
  );

  hgg_nbr_unit u_nbr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (nbr_ctrl),
    .col_i    (col_idx),
    .rd_row_i (rd_row),
    .thr_i    (min_nbr_q),
    .res_o    (nbr_res),
    .wb_row_o (wb_row)
  );

  hgg_grid_mem u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_row_o (rd_row)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int SIDE = hgg_pkg::GRID_SIDE;

  // Wrap any integer onto the torus
  function automatic int wrap_side(int v);
    return ((v % SIDE) + SIDE) % SIDE;
  endfunction

  // Growth predictor plus the queue of results it still expects
  class growth_scoreboard;
    bit                        grid [SIDE][SIDE];
    int                        dr [6] = '{-1, -1, 0, 1, 1, 0};
    int                        dc [6] = '{0, 1, 1, 0, -1, -1};
    logic [hgg_pkg::CNT_W-1:0] threshold;
    hgg_pkg::nbr_res_t         pending [$];
    int                        occupied_cells [$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               grown;

    function new();
      int mid;
      mid = SIDE / 2;
      threshold = 1;
      mark(mid, mid);
      for (int k = 0; k < 6; k++) mark(wrap_side(mid + dr[k]), wrap_side(mid + dc[k]));
    endfunction

    function void mark(int r, int c);
      if (!grid[r][c]) begin
        grid[r][c] = 1'b1;
        occupied_cells.push_back(r * SIDE + c);
      end
    endfunction

    function void set_threshold(logic [hgg_pkg::CNT_W-1:0] v);
      threshold = v;
    endfunction

    // Count the six hex neighbors, grow the cell, queue the result
    function void note_request(logic [hgg_pkg::IN_W-1:0] r_in,
                               logic [hgg_pkg::IN_W-1:0] c_in);
      int                r;
      int                c;
      int                n;
      hgg_pkg::nbr_res_t res;
      r = int'(r_in) % SIDE;
      c = int'(c_in) % SIDE;
      n = 0;
      for (int k = 0; k < 6; k++) n += grid[wrap_side(r + dr[k])][wrap_side(c + dc[k])];
      res.count = n[hgg_pkg::CNT_W-1:0];
      res.after = grid[r][c] || (n >= int'(threshold));
      res.newly = !grid[r][c] && (n >= int'(threshold));
      if (res.newly) begin
        mark(r, c);
        grown++;
      end
      pending.push_back(res);
    endfunction

    function void check_result(hgg_pkg::nbr_res_t got);
      hgg_pkg::nbr_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result count=%0d after=%0b newly=%0b",
                   got.count, got.after, got.newly);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.count !== want.count || got.after !== want.after ||
          got.newly !== want.newly) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: result %0d expected count=%0d after=%0b newly=%0b,",
                    " got count=%0d after=%0b newly=%0b"},
                   checked, want.count, want.after, want.newly,
                   got.count, got.after, got.newly);
      end
    endfunction

    function void flush_check();
      if (pending.size() != 0) begin
        $display("ERROR: %0d results never arrived", pending.size());
        errors += pending.size();
      end
    endfunction
  endclass

  // DUT signals
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [hgg_pkg::CNT_W-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [hgg_pkg::IN_W-1:0]  row_i       = '0;
  logic [hgg_pkg::IN_W-1:0]  col_i       = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [hgg_pkg::CNT_W-1:0] neighbour_count_o;
  logic                      occupied_after_o;
  logic                      newly_set_o;

  growth_scoreboard sb = new();

  // Sender state
  bit valid_on      = 1'b0;
  int burst_left    = 0;
  int gap_max       = 8;
  int requests      = 0;
  int settings_used = 1;
  // Receiver state
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_mode    = 0;
  int mode_left     = 0;

  hex_grid_growth_step dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .row_i             (row_i),
    .col_i             (col_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .neighbour_count_o (neighbour_count_o),
    .occupied_after_o  (occupied_after_o),
    .newly_set_o       (newly_set_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: check accepted results, then pick next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      sb.check_result(hgg_pkg::nbr_res_t'{neighbour_count_o, occupied_after_o,
                                          newly_set_o});
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ((mode_left % 5) < 2);
      endcase
    end
  end

  // Offer one request and hold it until taken; bursts end in random gaps
  task automatic send_cell(input logic [hgg_pkg::IN_W-1:0] r,
                           input logic [hgg_pkg::IN_W-1:0] c);
    int gap;
    in_valid_i <= 1'b1;
    row_i      <= r;
    col_i      <= c;
    valid_on = 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(r, c);
    requests++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every result is back and the block settles
  task automatic drain();
    if (valid_on) begin
      in_valid_i <= 1'b0;
      valid_on = 1'b0;
    end
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [hgg_pkg::CNT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(v);
    settings_used++;
  endtask

  // Mostly cells near the grown region, some anywhere, some on the edges
  task automatic pick_cell(output logic [hgg_pkg::IN_W-1:0] r,
                           output logic [hgg_pkg::IN_W-1:0] c);
    int sel;
    int idx;
    sel = $urandom_range(0, 9);
    if (sel < 6 && sb.occupied_cells.size() != 0) begin
      idx = sb.occupied_cells[$urandom_range(0, sb.occupied_cells.size() - 1)];
      r = hgg_pkg::IN_W'(wrap_side(idx / SIDE + int'($urandom_range(0, 4)) - 2));
      c = hgg_pkg::IN_W'(wrap_side(idx % SIDE + int'($urandom_range(0, 4)) - 2));
    end else if (sel < 8) begin
      r = hgg_pkg::IN_W'($urandom_range(0, SIDE - 1));
      c = hgg_pkg::IN_W'($urandom_range(0, SIDE - 1));
    end else begin
      r = $urandom_range(0, 1) ? hgg_pkg::IN_W'($urandom_range(0, 1))
                               : hgg_pkg::IN_W'(SIDE - 2 + $urandom_range(0, 1));
      c = $urandom_range(0, 1) ? hgg_pkg::IN_W'($urandom_range(0, 1))
                               : hgg_pkg::IN_W'(SIDE - 2 + $urandom_range(0, 1));
    end
  endtask

  // Main stimulus
  initial begin
    logic [hgg_pkg::CNT_W-1:0] phase_thr [10];
    logic [hgg_pkg::IN_W-1:0]  r;
    logic [hgg_pkg::IN_W-1:0]  c;
    phase_thr = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd1};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset threshold: seed center, seed ring, cells touching the seed and one just off it, corners
    send_cell(7'd64, 7'd64);
    send_cell(7'd63, 7'd64);
    send_cell(7'd62, 7'd64);
    send_cell(7'd64, 7'd62);
    send_cell(7'd66, 7'd64);
    send_cell(7'd65, 7'd66);
    send_cell(7'd0, 7'd0);
    send_cell(7'd127, 7'd127);
    send_cell(7'd0, 7'd127);
    send_cell(7'd127, 7'd0);
    drain();

    // Threshold zero: isolated cells grow, neighbors wrap across edges
    write_threshold(3'd0);
    send_cell(7'd0, 7'd0);
    send_cell(7'd0, 7'd1);
    send_cell(7'd127, 7'd0);
    send_cell(7'd127, 7'd127);
    send_cell(7'd1, 7'd127);
    send_cell(7'd0, 7'd127);
    drain();

    // Threshold seven: nothing grows even with full neighborhoods
    write_threshold(3'd7);
    send_cell(7'd126, 7'd0);
    send_cell(7'd1, 7'd0);
    send_cell(7'd64, 7'd63);
    drain();

    // Random phases across thresholds
    for (int p = 0; p < 10; p++) begin
      write_threshold(phase_thr[p]);
      gap_max = (p % 3 == 1) ? 0 : $urandom_range(2, 16);
      // receiver holds off while the sender keeps going
      if (p == 3) hold_requests++;
      for (int i = 0; i < 183; i++) begin
        // one mid-phase pause until everything is back
        if (p == 5 && i == 90) drain();
        pick_cell(r, c);
        send_cell(r, c);
      end
      drain();
    end

    sb.flush_check();
    $display("Covered %0d cell requests under %0d threshold settings, edges and wrap included;",
             requests, settings_used);
    $display("%0d results checked, %0d cells grown, %0d mismatches.",
             sb.checked, sb.grown, sb.errors);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
